>>> rtl/core/wxc_pkg.sv
// shared types, constants and helpers for the weighted xor check byte block
// no dependencies
`timescale 1ns / 1ps

package wxc_pkg;

   localparam int BYTE_W  = 8;
   localparam int MOD_W   = BYTE_W + 1;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASIC_MOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_MOD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SWAP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SEQ  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_RULE  = 3'd4;

   localparam logic [BYTE_W-1:0] BASIC_MOD_RST = 8'd11;
   localparam logic [BYTE_W-1:0] SWAP_MOD_RST  = 8'd16;
   localparam logic              INIT_SWAP_RST = 1'b0;
   localparam logic [BYTE_W-1:0] INIT_SEQ_RST  = 8'd13;
   localparam logic              SEQ_RULE_RST  = 1'b0;

   typedef struct packed {
      logic [BYTE_W-1:0] basic_mod;
      logic [BYTE_W-1:0] swap_mod;
      logic              init_swap;
      logic [BYTE_W-1:0] init_seq;
      logic              seq_rule;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] expected_check;
      logic              last_byte;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   // basic modulus of zero counts as 256
   function automatic logic [MOD_W-1:0] eff_mod(input logic [BYTE_W-1:0] m);
      eff_mod = (m == '0) ? {1'b1, {BYTE_W{1'b0}}} : {1'b0, m};
   endfunction

endpackage

>>> rtl/core/wxc_init_mod.sv
// restoring remainder unit: initial sequence modulo basic modulus, one bit a cycle
// depends on wxc_pkg
`timescale 1ns / 1ps

module wxc_init_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wxc_pkg::BYTE_W-1:0] dividend,
   input  logic [wxc_pkg::BYTE_W-1:0] modulus,
   output logic                       busy,
   output logic                       done,
   output logic [wxc_pkg::BYTE_W-1:0] result
);
   import wxc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0] div_ff, div_in;
   logic [MOD_W-1:0]  trial;
   logic [MOD_W-1:0]  m9;
   logic [MOD_W-1:0]  red;

   always_comb begin
      m9    = eff_mod(modulus);
      trial = {rem_ff, div_ff[BYTE_W-1]};
      red   = (trial >= m9) ? (trial - m9) : trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd7;
         rem_in  = '0;
         div_in  = dividend;
      end else if (busy_ff) begin
         rem_in = red[BYTE_W-1:0];
         div_in = {div_ff[BYTE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = rem_ff;

endmodule

>>> rtl/core/wxc_core.sv
// per-byte update of position residues, swap flag, sequence and check accumulator
// depends on wxc_pkg
`timescale 1ns / 1ps

module wxc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  wxc_pkg::cfg_type           cfg,
   input  logic                       rearm_load,
   input  logic [wxc_pkg::BYTE_W-1:0] rearm_seq,
   input  logic                       item_valid,
   input  wxc_pkg::item_type          item,
   output logic [wxc_pkg::BYTE_W-1:0] check_byte,
   output logic                       check_matches
);
   import wxc_pkg::*;

   logic [BYTE_W-1:0]   pos_basic_ff, pos_basic_in;
   logic [BYTE_W-1:0]   pos_swap_ff, pos_swap_in;
   logic                swap_ff, swap_in;
   logic [BYTE_W-1:0]   seq_ff, seq_in;
   logic [BYTE_W-1:0]   seq_init_ff, seq_init_in;
   logic [BYTE_W-1:0]   acc_ff, acc_in;

   logic [MOD_W-1:0]    m9;
   logic                selected;
   logic [MOD_W-1:0]    weight;
   logic [MOD_W-1:0]    sum9;
   logic [MOD_W-1:0]    seq_red;
   logic [2*BYTE_W-1:0] prod;
   logic [BYTE_W-1:0]   acc_next;
   logic [MOD_W-1:0]    pb_inc;
   logic [MOD_W-1:0]    ps_inc;
   logic [BYTE_W-1:0]   pb_rearm;
   logic [BYTE_W-1:0]   ps_rearm;

   always_comb begin
      m9       = eff_mod(cfg.basic_mod);
      selected = (pos_basic_ff == '0) != swap_ff;
      weight   = cfg.seq_rule ? ({1'b0, seq_ff} + 9'd1)
                              : ({1'b0, seq_ff} + {8'd0, seq_ff[0]} + 9'd1);
      sum9     = selected ? weight
                          : ({1'b0, seq_ff} + (cfg.seq_rule ? 9'd1 : 9'd2));
      // modulus of one keeps the sequence at zero
      seq_red  = (cfg.basic_mod == 8'd1) ? '0 : ((sum9 >= m9) ? (sum9 - m9) : sum9);
      prod     = weight[BYTE_W-1:0] * item.data_byte;
      acc_next = selected ? (acc_ff ^ prod[BYTE_W-1:0]) : acc_ff;
      pb_inc   = {1'b0, pos_basic_ff} + 9'd1;
      ps_inc   = {1'b0, pos_swap_ff} + 9'd1;
      pb_rearm = (cfg.basic_mod == 8'd1) ? 8'd0 : 8'd1;
      ps_rearm = (cfg.swap_mod == 8'd0 || cfg.swap_mod == 8'd1) ? 8'd0 : 8'd1;

      pos_basic_in = pos_basic_ff;
      pos_swap_in  = pos_swap_ff;
      swap_in      = swap_ff;
      seq_in       = seq_ff;
      seq_init_in  = seq_init_ff;
      acc_in       = acc_ff;

      if (rearm_load) begin
         seq_init_in  = rearm_seq;
         pos_basic_in = pb_rearm;
         pos_swap_in  = ps_rearm;
         swap_in      = cfg.init_swap;
         seq_in       = rearm_seq;
         acc_in       = '0;
      end else if (item_valid) begin
         if (item.last_byte) begin
            pos_basic_in = pb_rearm;
            pos_swap_in  = ps_rearm;
            swap_in      = cfg.init_swap;
            seq_in       = seq_init_ff;
            acc_in       = '0;
         end else begin
            pos_basic_in = (pb_inc == m9) ? '0 : pb_inc[BYTE_W-1:0];
            if (cfg.swap_mod != '0) begin
               swap_in     = (pos_swap_ff == '0) ? ~swap_ff : swap_ff;
               pos_swap_in = (ps_inc == {1'b0, cfg.swap_mod}) ? '0 : ps_inc[BYTE_W-1:0];
            end
            seq_in = seq_red[BYTE_W-1:0];
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_basic_ff <= 8'd1;
         pos_swap_ff  <= 8'd1;
         swap_ff      <= INIT_SWAP_RST;
         seq_ff       <= '0;
         seq_init_ff  <= '0;
         acc_ff       <= '0;
      end else begin
         pos_basic_ff <= pos_basic_in;
         pos_swap_ff  <= pos_swap_in;
         swap_ff      <= swap_in;
         seq_ff       <= seq_in;
         seq_init_ff  <= seq_init_in;
         acc_ff       <= acc_in;
      end
   end

   assign check_byte    = acc_next;
   assign check_matches = (acc_next == item.expected_check);

endmodule

>>> rtl/core/weighted_xor_check_byte.sv
// top level: configuration registers, input register, result register
// depends on wxc_pkg, wxc_init_mod, wxc_core
`timescale 1ns / 1ps

// Builds one check byte over each block of data bytes, the block ending with the
// item marked tlast; that item returns the check byte and whether it matches the
// expected byte. One byte is accepted every cycle unless re-arming or a stalled
// result blocks the last byte. Reset and each write to indices 0 to 4 re-arm the
// block: it takes no byte while an 8-step remainder unit reduces the initial
// sequence by the basic modulus; results come from the result register.

module weighted_xor_check_byte (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [wxc_pkg::REQ_W-1:0]     req_tdata,   // data_byte, expected_check
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [wxc_pkg::RSP_W-1:0]     rsp_tdata,   // check_byte, check_matches, zeros
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wxc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wxc_pkg::BYTE_W-1:0]    csr_data
);
   import wxc_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              start_ff, start_in;
   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff, s1_item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_check_ff, rsp_check_in;
   logic              rsp_match_ff, rsp_match_in;

   logic              mod_busy;
   logic              mod_done;
   logic [BYTE_W-1:0] mod_result;
   logic              hold;
   logic              csr_xfer;
   logic              req_xfer;
   logic              s1_fire;
   logic [BYTE_W-1:0] core_check;
   logic              core_match;

   wxc_init_mod u_init_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (cfg_ff.init_seq),
      .modulus  (cfg_ff.basic_mod),
      .busy     (mod_busy),
      .done     (mod_done),
      .result   (mod_result)
   );

   wxc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .rearm_load    (mod_done),
      .rearm_seq     (mod_result),
      .item_valid    (s1_fire),
      .item          (s1_item_ff),
      .check_byte    (core_check),
      .check_matches (core_match)
   );

   always_comb begin
      hold      = start_ff | mod_busy;
      csr_ready = ~hold;
      csr_xfer  = csr_valid & csr_ready;
      s1_fire   = s1_valid_ff & (~s1_item_ff.last_byte | ~rsp_valid_ff | rsp_tready);
      req_tready = ~hold & (~s1_valid_ff | s1_fire);
      req_xfer  = req_tvalid & req_tready;

      cfg_in   = cfg_ff;
      start_in = 1'b0;
      if (csr_xfer) begin
         start_in = 1'b1;
         case (csr_index)
            CSR_BASIC_MOD: cfg_in.basic_mod = csr_data;
            CSR_SWAP_MOD:  cfg_in.swap_mod  = csr_data;
            CSR_INIT_SWAP: cfg_in.init_swap = csr_data[0];
            CSR_INIT_SEQ:  cfg_in.init_seq  = csr_data;
            CSR_SEQ_RULE:  cfg_in.seq_rule  = csr_data[0];
            default:       start_in = 1'b0;
         endcase
      end

      s1_valid_in = req_xfer | (s1_valid_ff & ~s1_fire);
      s1_item_in  = s1_item_ff;
      if (req_xfer) begin
         s1_item_in.data_byte      = req_tdata[BYTE_W-1:0];
         s1_item_in.last_byte      = req_tlast;
         s1_item_in.expected_check = req_tdata[2*BYTE_W-1:BYTE_W];
      end

      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_check_in = rsp_check_ff;
      rsp_match_in = rsp_match_ff;
      if (s1_fire & s1_item_ff.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_check_in = core_check;
         rsp_match_in = core_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.basic_mod <= BASIC_MOD_RST;
         cfg_ff.swap_mod  <= SWAP_MOD_RST;
         cfg_ff.init_swap <= INIT_SWAP_RST;
         cfg_ff.init_seq  <= INIT_SEQ_RST;
         cfg_ff.seq_rule  <= SEQ_RULE_RST;
         start_ff         <= 1'b1;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         start_ff     <= start_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff   <= s1_item_in;
      rsp_check_ff <= rsp_check_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-BYTE_W-1){1'b0}}, rsp_match_ff, rsp_check_ff};

endmodule

>>> rtl/core/wxc_checker.sv
// port-level checks for weighted_xor_check_byte, bound to the top level
// depends on wxc_pkg
`timescale 1ns / 1ps

module wxc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [wxc_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [wxc_pkg::CSR_IDX_W-1:0] csr_index
);
   import wxc_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // padding bits of the result stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:BYTE_W+1] == '0)
      else $error("result padding not zero");

   // no byte taken right after reset while the initial remainder runs
   a_reset_hold: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready && !csr_ready)
      else $error("ready right after reset");

   // a register write blocks both channels while re-arming
   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index <= CSR_SEQ_RULE |=> !req_tready && !csr_ready)
      else $error("ready during re-arm");

endmodule

bind weighted_xor_check_byte wxc_checker u_wxc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index)
);

>>> tb/tb_top.sv
// self-checking testbench for weighted_xor_check_byte: stream driver, stream monitor,
// register writes between phases, predictor kept in step with accepted transfers
// depends on wxc_pkg and the weighted_xor_check_byte rtl
`timescale 1ns / 1ps

module tb_top;
   import wxc_pkg::*;

   localparam int EXP_RANDOM = -1;
   localparam int EXP_TRUE   = -2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = CSR_SEQ_RULE + 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] pos_basic;
      logic [BYTE_W-1:0] pos_swap;
      logic              swap_on;
      logic [BYTE_W-1:0] seq_res;
      logic [BYTE_W-1:0] acc;
   } chk_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] check_byte;
      logic              check_matches;
   } check_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_data = '0;

   cfg_type          cur_cfg;
   chk_state_type    model_state;
   chk_state_type    gen_state;
   item_type         byte_feed[$];
   item_type         on_bus;
   check_result_type pending_checks[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               errors = 0;

   weighted_xor_check_byte DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int modulus_of(input cfg_type c);
      return (c.basic_mod == '0) ? 256 : int'(c.basic_mod);
   endfunction

   function automatic chk_state_type armed_state(input cfg_type c);
      chk_state_type s;
      s.pos_basic = 8'(1 % modulus_of(c));
      s.pos_swap  = (c.swap_mod == '0) ? '0 : 8'(1 % c.swap_mod);
      s.swap_on   = c.init_swap;
      s.seq_res   = 8'(c.init_seq % modulus_of(c));
      s.acc       = '0;
      return s;
   endfunction

   // advances the check state by one byte, returns 1 when the block closes
   function automatic bit weigh_byte(inout chk_state_type s, input cfg_type c,
                                     input item_type it, output check_result_type res);
      int m;
      int r;
      int v;
      bit sel;
      m = modulus_of(c);
      r = s.seq_res % m;
      sel = (s.pos_basic == '0) != s.swap_on;
      if (sel) begin
         v = c.seq_rule ? r + 1 : r + (r % 2) + 1;
         s.acc = s.acc ^ 8'((v % 256) * it.data_byte);
         s.seq_res = 8'(v % m);
      end else begin
         s.seq_res = 8'((r + (c.seq_rule ? 1 : 2)) % m);
      end
      if (c.swap_mod != '0) begin
         if (s.pos_swap == '0) s.swap_on = ~s.swap_on;
         s.pos_swap = 8'((s.pos_swap + 1) % c.swap_mod);
      end
      s.pos_basic = 8'((s.pos_basic + 1) % m);
      res.check_byte = s.acc;
      res.check_matches = (s.acc == it.expected_check);
      if (it.last_byte) s = armed_state(c);
      return it.last_byte;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   // input transfers
   always @(posedge clock) begin
      check_result_type res;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (weigh_byte(model_state, cur_cfg, on_bus, res))
               pending_checks = {pending_checks, res};
         end
         if (!req_tvalid || req_tready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = byte_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {on_bus.expected_check, on_bus.data_byte};
               req_tlast <= on_bus.last_byte;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result transfers
   always @(posedge clock) begin
      check_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_checks.size() == 0) begin
               report_mismatch("unexpected result, check_byte", rsp_tdata[7:0], 0);
            end else begin
               want = pending_checks.pop_front();
               if (rsp_tdata[7:0] !== want.check_byte)
                  report_mismatch("check_byte", rsp_tdata[7:0], want.check_byte);
               if (rsp_tdata[8] !== want.check_matches)
                  report_mismatch("check_matches", rsp_tdata[8], want.check_matches);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic wait_drained();
      while (byte_feed.size() != 0 || req_tvalid || pending_checks.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      bit known;
      known = 1'b1;
      wait_drained();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BASIC_MOD: cur_cfg.basic_mod = value;
         CSR_SWAP_MOD:  cur_cfg.swap_mod = value;
         CSR_INIT_SWAP: cur_cfg.init_swap = value[0];
         CSR_INIT_SEQ:  cur_cfg.init_seq = value;
         CSR_SEQ_RULE:  cur_cfg.seq_rule = value[0];
         default:       known = 1'b0;
      endcase
      if (known) begin
         model_state = armed_state(cur_cfg);
         gen_state = armed_state(cur_cfg);
      end
   endtask

   task automatic write_all(input logic [BYTE_W-1:0] basic, input logic [BYTE_W-1:0] swap,
                            input logic iswap, input logic [BYTE_W-1:0] iseq,
                            input logic rule);
      write_csr(CSR_BASIC_MOD, basic);
      write_csr(CSR_SWAP_MOD, swap);
      write_csr(CSR_INIT_SWAP, {7'($urandom), iswap});
      write_csr(CSR_INIT_SEQ, iseq);
      write_csr(CSR_SEQ_RULE, {7'($urandom), rule});
   endtask

   // expected < 0 picks the expected byte of a closing item: always the true check, or random half the time
   task automatic queue_item(input logic [BYTE_W-1:0] data, input bit last, input int expected);
      item_type it;
      check_result_type res;
      it.data_byte = data;
      it.last_byte = last;
      it.expected_check = (expected < 0) ? 8'($urandom) : 8'(expected);
      if (weigh_byte(gen_state, cur_cfg, it, res)) begin
         if (expected == EXP_TRUE || (expected == EXP_RANDOM && $urandom_range(1)))
            it.expected_check = res.check_byte;
      end
      byte_feed = {byte_feed, it};
   endtask

   task automatic queue_block(input int len, input bit close);
      int k;
      int pick;
      logic [BYTE_W-1:0] data;
      for (k = 1; k <= len; k++) begin
         pick = $urandom_range(99);
         data = (pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF : 8'($urandom);
         queue_item(data, close && k == len, EXP_RANDOM);
      end
   endtask

   function automatic int block_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return $urandom_range(1, 16);
      if (pick < 95) return $urandom_range(17, 64);
      return $urandom_range(65, 300);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_modulus();
      return ($urandom_range(1)) ? 8'($urandom_range(1, 24)) : 8'($urandom);
   endfunction

   initial begin
      logic [BYTE_W-1:0] pattern [6];
      int ph;
      int sent;
      int k;
      pattern = '{8'hFF, 8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55};
      cur_cfg = '{basic_mod: BASIC_MOD_RST, swap_mod: SWAP_MOD_RST, init_swap: INIT_SWAP_RST,
                  init_seq: INIT_SEQ_RST, seq_rule: SEQ_RULE_RST};
      model_state = armed_state(cur_cfg);
      gen_state = armed_state(cur_cfg);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: single-byte blocks, one long enough to pass a swap toggle, then a two-byte block
      queue_item(8'hFF, 1'b1, EXP_TRUE);
      queue_item(8'h00, 1'b1, 8'hFF);
      for (k = 1; k <= 20; k++) queue_item(pattern[k % 6], k == 20, EXP_TRUE);
      queue_item(8'h5A, 1'b0, 8'h00);
      queue_item(8'hA5, 1'b1, 8'hFF);

      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         case (ph)
            0: write_all(8'd255, 8'd255, 1'b1, 8'd0, 1'b0);
            1: write_all(8'd0, 8'd1, 1'b0, 8'd255, 1'b1);
            2: write_all(8'd1, 8'd0, 1'b0, 8'd200, 1'b0);
            3: write_all(8'd0, 8'd0, 1'b1, 8'd255, 1'b0);
            default: write_all(pick_modulus(), pick_modulus(), 1'($urandom),
                               8'($urandom), 1'($urandom));
         endcase
         sent = 0;
         while (sent < 110) begin
            k = block_len();
            queue_block(k, 1'b1);
            sent += k;
         end
         // open block: either dropped by the next write or carried over an unused index
         if ($urandom_range(1)) begin
            queue_block($urandom_range(1, 9), 1'b0);
            if ($urandom_range(1)) begin
               write_csr(CSR_UNUSED_LO + CSR_IDX_W'($urandom_range(2)), 8'($urandom));
               queue_block($urandom_range(1, 9), 1'b1);
            end
         end
      end

      wait_drained();
      if (errors == 0) begin
         $display("weighted_xor_check_byte test passed");
      end else begin
         $display("weighted_xor_check_byte test failed");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("weighted_xor_check_byte test failed");
      $finish;
   end

endmodule
